FILE: sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RMH_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RMH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/rmh_pkg.sv
// shared constants, types and codes of the region motion histogram
// no dependencies
package rmh_pkg;

  localparam int unsigned FRAME_PIXELS = 262144;
  localparam int unsigned NUM_BINS     = 256;

  localparam int unsigned POS_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned BIN_W = $clog2(NUM_BINS);
  localparam int unsigned CNT_W = 19;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned LBL_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [PIX_W-1:0] PIX_MAX  = '1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_PIXELS - 1);

  // grey conversion, coefficients sum to 1 << GREY_SHIFT
  localparam int unsigned      GREY_W     = 22;
  localparam int unsigned      GREY_SHIFT = 14;
  localparam logic [13:0]      COEF_R     = 14'd4899;
  localparam logic [13:0]      COEF_G     = 14'd9617;
  localparam logic [13:0]      COEF_B     = 14'd1868;
  localparam logic [GREY_W-1:0] GREY_RND  = GREY_W'(8192);

  // item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // register port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0]  REG_HOLD = 2'd0;
  localparam logic [1:0]  REG_THR  = 2'd1;
  localparam logic [1:0]  REG_SHOW = 2'd2;
  localparam logic [7:0]  THR_RESET = 8'd25;

  // queues, depth is a power of two
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic       hold;
    logic [7:0] thr;
    logic       show;
  } cfg_t;

  typedef struct packed {
    logic              is_read;
    logic              clear;
    logic              in_range;
    logic [LBL_W-1:0]  label;
    logic [POS_W-1:0]  pos;
    logic [PIX_W-1:0]  grey;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] changed;
  } hist_t;

  typedef struct packed {
    logic [PIX_W-1:0] diff_pixel;
    hist_t            counts;
  } res_t;

endpackage

FILE: sv/rmh_front.sv
// front end: input handshake, grey conversion, pixel position tracking
// depends on rmh_pkg
module rmh_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic                     operation_i,
  input  logic [7:0]               blue_i,
  input  logic [7:0]               green_i,
  input  logic [7:0]               red_i,
  input  logic [rmh_pkg::LBL_W-1:0] region_label_i,
  input  logic                     frame_start_i,
  input  logic                     cmdq_full_i,
  input  logic                     clearing_i,
  output logic                     full_o,
  output logic                     cmd_push_o,
  output rmh_pkg::cmd_t            cmd_o
);

  logic [rmh_pkg::POS_W-1:0]  pos_q, pos_d, pos_cur;
  logic [rmh_pkg::GREY_W-1:0] grey_sum;
  logic                       is_pixel;

  assign full_o     = cmdq_full_i | clearing_i;
  assign cmd_push_o = push_i & ~full_o;
  assign is_pixel   = (operation_i == rmh_pkg::OP_PIXEL);

  assign grey_sum = rmh_pkg::GREY_W'(rmh_pkg::COEF_R) * rmh_pkg::GREY_W'(red_i)
                  + rmh_pkg::GREY_W'(rmh_pkg::COEF_G) * rmh_pkg::GREY_W'(green_i)
                  + rmh_pkg::GREY_W'(rmh_pkg::COEF_B) * rmh_pkg::GREY_W'(blue_i)
                  + rmh_pkg::GREY_RND;

  // frame start restarts the raster position
  assign pos_cur = frame_start_i ? '0 : pos_q;

  always_comb begin
    pos_d = pos_q;
    if (cmd_push_o && is_pixel) begin
      pos_d = (pos_cur == rmh_pkg::POS_LAST) ? '0 : pos_cur + 1'b1;
    end
  end

  always_comb begin
    cmd_o.is_read  = ~is_pixel;
    cmd_o.clear    = is_pixel & frame_start_i;
    cmd_o.in_range = ({1'b0, region_label_i} < 9'(rmh_pkg::NUM_BINS));
    cmd_o.label    = region_label_i;
    cmd_o.pos      = pos_cur;
    cmd_o.grey     = grey_sum[rmh_pkg::GREY_SHIFT +: rmh_pkg::PIX_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

FILE: sv/rmh_cmdq.sv
// command queue between the front end and the back end
// depends on rmh_pkg
module rmh_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rmh_pkg::cmd_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output rmh_pkg::cmd_t data_o
);

  rmh_pkg::cmd_t                entries_q [rmh_pkg::QDEPTH];
  logic [rmh_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [rmh_pkg::QCNT_W-1:0]   count_q;

  assign full_o  = (count_q == rmh_pkg::QCNT_W'(rmh_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + rmh_pkg::QCNT_W'(push_i) - rmh_pkg::QCNT_W'(pop_i);
    end
  end

endmodule

FILE: sv/rmh_outq.sv
// result queue feeding the output ports
// depends on rmh_pkg
module rmh_outq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  rmh_pkg::res_t              data_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output rmh_pkg::res_t              data_o,
  output logic [rmh_pkg::QCNT_W-1:0] count_o
);

  rmh_pkg::res_t                entries_q [rmh_pkg::QDEPTH];
  logic [rmh_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [rmh_pkg::QCNT_W-1:0]   count_q;
  logic                         pop_ok;

  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign count_o = count_q;
  assign pop_ok  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_ok) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + rmh_pkg::QCNT_W'(push_i) - rmh_pkg::QCNT_W'(pop_ok);
    end
  end

endmodule

FILE: sv/rmh_back.sv
// back end: reference frame and histogram memories, update pipeline, reset sweep
// depends on rmh_pkg
module rmh_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rmh_pkg::cfg_t              cfg_i,
  input  logic                       cmd_valid_i,
  input  rmh_pkg::cmd_t              cmd_i,
  input  logic [rmh_pkg::QCNT_W-1:0] outq_count_i,
  output logic                       cmd_pop_o,
  output logic                       res_valid_o,
  output rmh_pkg::res_t              res_o,
  output logic                       clearing_o
);

  localparam logic [rmh_pkg::QCNT_W:0] OUT_SLOTS = (rmh_pkg::QCNT_W + 1)'(rmh_pkg::QDEPTH);

  function automatic logic [rmh_pkg::CNT_W-1:0] sat_inc(input logic [rmh_pkg::CNT_W-1:0] v);
    return (v == rmh_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  // memories
  logic [rmh_pkg::PIX_W-1:0] ref_mem  [rmh_pkg::FRAME_PIXELS];
  rmh_pkg::hist_t            hist_mem [rmh_pkg::NUM_BINS];
  logic [rmh_pkg::PIX_W-1:0] ref_rd_q;
  rmh_pkg::hist_t            hist_rd_q;

  // reset sweep over the reference frame
  logic                      clearing_q, clearing_d;
  logic [rmh_pkg::POS_W-1:0] clr_cnt_q, clr_cnt_d;

  // update stage
  logic                      s1_valid_q;
  rmh_pkg::cmd_t             s1_q;
  logic [rmh_pkg::BIN_W-1:0] s1_bin;

  // bypass of the previous cycle's writes
  logic                      rfw_valid_q;
  logic [rmh_pkg::POS_W-1:0] rfw_pos_q;
  logic [rmh_pkg::PIX_W-1:0] rfw_data_q;
  logic                      hfw_valid_q;
  logic [rmh_pkg::BIN_W-1:0] hfw_bin_q;
  rmh_pkg::hist_t            hfw_data_q;

  logic [rmh_pkg::NUM_BINS-1:0] hv_q, hv_d;

  logic [rmh_pkg::QCNT_W:0]  slots_used;
  logic                      issue;
  logic [rmh_pkg::PIX_W-1:0] ref_cur, diff;
  logic [rmh_pkg::PIX_W:0]   pix_sum;
  logic [rmh_pkg::PIX_W-1:0] pix;
  logic                      changed;
  rmh_pkg::hist_t            hist_cur, hist_new;
  logic                      pix_we, hist_we, ref_item_we, ref_we;
  logic [rmh_pkg::POS_W-1:0] ref_waddr;
  logic [rmh_pkg::PIX_W-1:0] ref_wdata;

  assign clearing_o = clearing_q;

  // credit: every issued item has a slot waiting in the result queue
  assign slots_used = {1'b0, outq_count_i} + {{rmh_pkg::QCNT_W{1'b0}}, s1_valid_q};
  assign issue      = cmd_valid_i & ~clearing_q & (slots_used < OUT_SLOTS);
  assign cmd_pop_o  = issue;

  assign s1_bin = s1_q.label[rmh_pkg::BIN_W-1:0];

  always_comb begin
    ref_cur = (rfw_valid_q && rfw_pos_q == s1_q.pos) ? rfw_data_q : ref_rd_q;
    diff    = (s1_q.grey > ref_cur) ? s1_q.grey - ref_cur : '0;
    changed = (diff > cfg_i.thr);
    pix_sum = {1'b0, diff} + {1'b0, s1_q.label};
    if (cfg_i.show) begin
      pix = pix_sum[rmh_pkg::PIX_W] ? rmh_pkg::PIX_MAX : pix_sum[rmh_pkg::PIX_W-1:0];
    end else begin
      pix = diff;
    end
  end

  always_comb begin
    if (s1_q.clear) begin
      hist_cur = '0;
    end else if (hfw_valid_q && hfw_bin_q == s1_bin) begin
      hist_cur = hfw_data_q;
    end else if (hv_q[s1_bin]) begin
      hist_cur = hist_rd_q;
    end else begin
      hist_cur = '0;
    end
    hist_new.total   = sat_inc(hist_cur.total);
    hist_new.changed = changed ? sat_inc(hist_cur.changed) : hist_cur.changed;
  end

  assign pix_we      = s1_valid_q & ~s1_q.is_read;
  assign hist_we     = pix_we & s1_q.in_range;
  assign ref_item_we = pix_we & ~cfg_i.hold;
  assign ref_we      = clearing_q | ref_item_we;
  assign ref_waddr   = clearing_q ? clr_cnt_q : s1_q.pos;
  assign ref_wdata   = clearing_q ? '0 : s1_q.grey;

  always_comb begin
    hv_d = hv_q;
    if (pix_we && s1_q.clear) hv_d = '0;
    if (hist_we) hv_d[s1_bin] = 1'b1;
  end

  always_comb begin
    res_valid_o = s1_valid_q;
    if (s1_q.is_read) begin
      res_o.diff_pixel = '0;
      res_o.counts     = s1_q.in_range ? hist_cur : '0;
    end else begin
      res_o.diff_pixel = pix;
      res_o.counts     = '0;
    end
  end

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == rmh_pkg::POS_LAST) clearing_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
    ref_rd_q <= ref_mem[cmd_i.pos];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[s1_bin] <= hist_new;
    hist_rd_q <= hist_mem[cmd_i.label[rmh_pkg::BIN_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    s1_q       <= cmd_i;
    rfw_pos_q  <= s1_q.pos;
    rfw_data_q <= s1_q.grey;
    hfw_bin_q  <= s1_bin;
    hfw_data_q <= hist_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      rfw_valid_q <= 1'b0;
      hfw_valid_q <= 1'b0;
      hv_q        <= '0;
    end else begin
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= issue;
      rfw_valid_q <= ref_item_we;
      hfw_valid_q <= hist_we;
      hv_q        <= hv_d;
    end
  end

endmodule

FILE: sv/region_motion_histogram.sv
// top level of the region motion histogram: register port, front end,
// command queue, back end and result queue; depends on rmh_pkg and the rmh_* modules
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------------
//   input     | push / full          | operation, blue, green, red, label, frame_start
//   result    | pop / empty          | diff_pixel, total_count, changed_count
//   register  | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// one item per clock sustained while results are popped and no reset sweep runs;
// an accepted item is registered in the command queue, then its memory read into
// the update stage, and its result then waits in the result queue while pop is held low
// after reset full stays high while all FRAME_PIXELS (262144) positions of the
// reference frame memory are swept to zero; registers can be written meanwhile
// histogram updates are read-modify-write on a registered memory, with a bypass
// of the previous write, so back-to-back pixels of one label need no stall
// a stalled result side backs up the result queue, then the command queue,
// then raises full
module region_motion_histogram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input items
  input  logic                        push,
  output logic                        full,
  input  logic                        operation_i,
  input  logic [7:0]                  blue_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  red_i,
  input  logic [7:0]                  region_label_i,
  input  logic                        frame_start_i,
  // results
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  diff_pixel_o,
  output logic [18:0]                 total_count_o,
  output logic [18:0]                 changed_count_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmh_pkg::ADDR_W-1:0]  paddr,
  input  logic [rmh_pkg::DATA_W-1:0]  pwdata,
  output logic [rmh_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // configuration registers
  rmh_pkg::cfg_t cfg_q, cfg_d;
  logic          reg_wr;
  logic [1:0]    reg_idx;

  // internal transfers
  logic                       cmd_push, cmd_pop, cmdq_full, cmdq_empty;
  rmh_pkg::cmd_t              cmd_in, cmd_head;
  logic                       clearing;
  logic                       res_valid;
  rmh_pkg::res_t              res_in, res_head;
  logic [rmh_pkg::QCNT_W-1:0] outq_count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (reg_wr) begin
      case (reg_idx)
        rmh_pkg::REG_HOLD: cfg_d.hold = pwdata[0];
        rmh_pkg::REG_THR:  cfg_d.thr  = pwdata[7:0];
        rmh_pkg::REG_SHOW: cfg_d.show = pwdata[0];
        default:           cfg_d      = cfg_q;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      rmh_pkg::REG_HOLD: prdata = {{(rmh_pkg::DATA_W-1){1'b0}}, cfg_q.hold};
      rmh_pkg::REG_THR:  prdata = {{(rmh_pkg::DATA_W-8){1'b0}}, cfg_q.thr};
      rmh_pkg::REG_SHOW: prdata = {{(rmh_pkg::DATA_W-1){1'b0}}, cfg_q.show};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold <= 1'b0;
      cfg_q.thr  <= rmh_pkg::THR_RESET;
      cfg_q.show <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // accept, convert to grey, track the raster position
  rmh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .operation_i    (operation_i),
    .blue_i         (blue_i),
    .green_i        (green_i),
    .red_i          (red_i),
    .region_label_i (region_label_i),
    .frame_start_i  (frame_start_i),
    .cmdq_full_i    (cmdq_full),
    .clearing_i     (clearing),
    .full_o         (full),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  // decouples the front end from memory-side stalls
  rmh_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .full_o  (cmdq_full),
    .empty_o (cmdq_empty),
    .data_o  (cmd_head)
  );

  // difference, reference update and histogram update
  rmh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (~cmdq_empty),
    .cmd_i        (cmd_head),
    .outq_count_i (outq_count),
    .cmd_pop_o    (cmd_pop),
    .res_valid_o  (res_valid),
    .res_o        (res_in),
    .clearing_o   (clearing)
  );

  // results wait here until popped
  rmh_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_head),
    .count_o (outq_count)
  );

  assign diff_pixel_o    = res_head.diff_pixel;
  assign total_count_o   = res_head.counts.total;
  assign changed_count_o = res_head.counts.changed;

endmodule

FILE: sv/rmh_checker.sv
// port-level checks of the region motion histogram, bound to the top level
// depends on assert_macros.svh and region_motion_histogram
`include "assert_macros.svh"

module rmh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  diff_pixel_o,
  input logic [18:0] total_count_o,
  input logic [18:0] changed_count_o
);

  // a waiting result is not withdrawn
  `RMH_ASSERT_NEXT(a_result_held, !empty && !pop, !empty, "result withdrawn")

  // a stalled result keeps its payload
  `RMH_ASSERT_NEXT(a_result_stable, !empty && !pop, $stable(diff_pixel_o) && $stable(total_count_o) && $stable(changed_count_o), "stalled result changed")

  // pixel results carry no counts
  `RMH_ASSERT_NOW(a_pixel_no_counts, !empty && diff_pixel_o != 8'd0, total_count_o == 19'd0 && changed_count_o == 19'd0, "pixel result with counts")

  // changed pixels are a subset of all pixels in a bin
  `RMH_ASSERT_NOW(a_changed_le_total, !empty, changed_count_o <= total_count_o, "changed count above total")

  // the reference sweep blocks input right after reset
  `RMH_ASSERT_NOW(a_sweep_blocks, $rose(rst_ni), full, "input open during reset sweep")

endmodule

bind region_motion_histogram rmh_checker u_rmh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .diff_pixel_o    (diff_pixel_o),
  .total_count_o   (total_count_o),
  .changed_count_o (changed_count_o)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for region_motion_histogram: queue-style input and result
// transfers, register writes over the apb port, scoreboard with its own motion model
// depends on rmh_pkg and the region_motion_histogram rtl
module tb_top;

  // index with no register behind it, writes there must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // pixels per short frame in the full-rate opening run
  localparam int unsigned RUN_PIXELS = 16;

  typedef struct packed {
    logic       op;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] label;
    logic       start;
  } pixel_item_t;

  // motion model plus the queue of expected results
  class motion_scoreboard;
    bit [rmh_pkg::PIX_W-1:0] ref_grey [rmh_pkg::FRAME_PIXELS];
    bit [rmh_pkg::CNT_W-1:0] pixel_cnt [rmh_pkg::NUM_BINS];
    bit [rmh_pkg::CNT_W-1:0] moved_cnt [rmh_pkg::NUM_BINS];
    bit [rmh_pkg::POS_W-1:0] pos;
    bit                      hold;
    bit [7:0]                thr;
    bit                      show;
    rmh_pkg::res_t           expected_q [$];
    int unsigned             errors;
    int unsigned             n_items;
    int unsigned             n_reads;
    int unsigned             n_checked;

    function new();
      thr = rmh_pkg::THR_RESET;
    endfunction

    function void set_register(logic [1:0] idx, logic [rmh_pkg::DATA_W-1:0] value);
      case (idx)
        rmh_pkg::REG_HOLD: hold = value[0];
        rmh_pkg::REG_THR:  thr  = value[7:0];
        rmh_pkg::REG_SHOW: show = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function void note_item(pixel_item_t it);
      rmh_pkg::res_t r;
      int unsigned   acc;
      bit [7:0]      grey;
      bit [7:0]      diff;
      bit [8:0]      sum;
      r = '0;
      n_items++;
      if (it.op == rmh_pkg::OP_READ) begin
        // a read leaves all state alone, frame start included
        n_reads++;
        if (int'(it.label) < rmh_pkg::NUM_BINS) begin
          r.counts.total   = pixel_cnt[it.label];
          r.counts.changed = moved_cnt[it.label];
        end
      end else begin
        if (it.start) begin
          for (int i = 0; i < rmh_pkg::NUM_BINS; i++) begin
            pixel_cnt[i] = '0;
            moved_cnt[i] = '0;
          end
          pos = '0;
        end
        acc  = rmh_pkg::COEF_R * it.red + rmh_pkg::COEF_G * it.green
             + rmh_pkg::COEF_B * it.blue + 32'd8192;
        grey = 8'(acc >> rmh_pkg::GREY_SHIFT);
        diff = (grey > ref_grey[pos]) ? grey - ref_grey[pos] : 8'd0;
        if (!hold) ref_grey[pos] = grey;
        if (int'(it.label) < rmh_pkg::NUM_BINS) begin
          if (pixel_cnt[it.label] != rmh_pkg::CNT_MAX) pixel_cnt[it.label]++;
          if (diff > thr && moved_cnt[it.label] != rmh_pkg::CNT_MAX) moved_cnt[it.label]++;
        end
        // label overlay clips at white
        sum = {1'b0, diff} + {1'b0, it.label};
        r.diff_pixel = !show ? diff : (sum[8] ? rmh_pkg::PIX_MAX : sum[7:0]);
        pos = (pos == rmh_pkg::POS_LAST) ? '0 : pos + 1'b1;
      end
      expected_q.push_back(r);
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic [7:0] diff, logic [18:0] total, logic [18:0] changed);
      rmh_pkg::res_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (diff !== e.diff_pixel)
        flag_mismatch($sformatf("diff_pixel %0d, expected %0d", diff, e.diff_pixel));
      if (total !== e.counts.total)
        flag_mismatch($sformatf("total_count %0d, expected %0d", total, e.counts.total));
      if (changed !== e.counts.changed)
        flag_mismatch($sformatf("changed_count %0d, expected %0d", changed,
                                e.counts.changed));
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       push;
  logic                       full;
  logic                       operation_i;
  logic [7:0]                 blue_i;
  logic [7:0]                 green_i;
  logic [7:0]                 red_i;
  logic [7:0]                 region_label_i;
  logic                       frame_start_i;
  logic                       empty;
  logic                       pop;
  logic [7:0]                 diff_pixel_o;
  logic [18:0]                total_count_o;
  logic [18:0]                changed_count_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [rmh_pkg::ADDR_W-1:0] paddr;
  logic [rmh_pkg::DATA_W-1:0] pwdata;
  logic [rmh_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  motion_scoreboard sb;

  // per-side idling switches and the long result-side hold-off
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_holdoff;

  region_motion_histogram dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .operation_i     (operation_i),
    .blue_i          (blue_i),
    .green_i         (green_i),
    .red_i           (red_i),
    .region_label_i  (region_label_i),
    .frame_start_i   (frame_start_i),
    .empty           (empty),
    .pop             (pop),
    .diff_pixel_o    (diff_pixel_o),
    .total_count_o   (total_count_o),
    .changed_count_o (changed_count_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop, several times the slowest legal run including the reset sweep
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic pixel_item_t mk(logic op, int r, int g, int b, int label, logic start);
    pixel_item_t it;
    it.op    = op;
    it.red   = 8'(r);
    it.green = 8'(g);
    it.blue  = 8'(b);
    it.label = 8'(label);
    it.start = start;
    return it;
  endfunction

  // mostly short frames over a few labels with reads mixed in, some noise
  function automatic pixel_item_t rand_item(bit first);
    pixel_item_t it;
    it.op    = (!first && $urandom_range(0, 99) < 15) ? rmh_pkg::OP_READ : rmh_pkg::OP_PIXEL;
    it.red   = 8'($urandom_range(0, 255));
    it.green = 8'($urandom_range(0, 255));
    it.blue  = 8'($urandom_range(0, 255));
    it.label = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 7));
    it.start = first || ($urandom_range(0, 49) == 0);
    return it;
  endfunction

  // one input transfer; full is looked at on the falling edge before each rising edge
  task automatic send_item(input pixel_item_t it);
    int unsigned idle_n;
    idle_n = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (idle_n > 0) begin
      push <= 1'b0;
      repeat (idle_n) @(posedge clk_i);
    end
    push           <= 1'b1;
    operation_i    <= it.op;
    blue_i         <= it.blue;
    green_i        <= it.green;
    red_i          <= it.red;
    region_label_i <= it.label;
    frame_start_i  <= it.start;
    do @(negedge clk_i); while (full);
    @(posedge clk_i);
    sb.note_item(it);
  endtask

  // setup then access phase, write lands on the edge with pready seen high
  task automatic write_reg(input logic [1:0] idx, input logic [rmh_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic set_config(input bit hold, input int thr, input bit show);
    write_reg(rmh_pkg::REG_HOLD, rmh_pkg::DATA_W'(hold));
    write_reg(rmh_pkg::REG_THR, rmh_pkg::DATA_W'(thr));
    write_reg(rmh_pkg::REG_SHOW, rmh_pkg::DATA_W'(show));
  endtask

  // stop offering and wait for every expected result, plus pipeline slack
  task automatic settle();
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // result side: random idling, optional long hold-off, then a transfer
  initial begin
    int unsigned idle_n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      idle_n = (rx_holdoff > 0) ? rx_holdoff : (rx_idle_on ? $urandom_range(0, 10) : 0);
      rx_holdoff = 0;
      if (idle_n > 0) begin
        pop <= 1'b0;
        repeat (idle_n) @(posedge clk_i);
      end
      pop <= 1'b1;
      // the head result is stable between edges, sample it before the popping edge
      do @(negedge clk_i); while (empty);
      sb.check_result(diff_pixel_o, total_count_o, changed_count_o);
      @(posedge clk_i);
    end
  end

  initial begin
    int lo;
    int hi;
    sb = new();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_holdoff = 0;
    rst_ni         <= 1'b0;
    push           <= 1'b0;
    operation_i    <= rmh_pkg::OP_PIXEL;
    blue_i         <= '0;
    green_i        <= '0;
    red_i          <= '0;
    region_label_i <= '0;
    frame_start_i  <= 1'b0;
    pop            <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers are writable during the post-reset memory sweep
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    set_config(1'b0, 0, 1'b0);

    // two short frames of one label at full rate: the first is dark, the second
    // strictly brighter at the same positions, so every pixel of it counts as changed
    for (int n = 0; n < 2 * RUN_PIXELS; n++) begin
      lo = (n < RUN_PIXELS) ? 8 : 136;
      hi = (n < RUN_PIXELS) ? 120 : 255;
      send_item(mk(rmh_pkg::OP_PIXEL, $urandom_range(lo, hi), $urandom_range(lo, hi),
                   $urandom_range(lo, hi), 7, (n % RUN_PIXELS) == 0));
    end
    for (int n = 0; n < 4; n++)
      send_item(mk(rmh_pkg::OP_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), (n % 2 == 0) ? 7 : 9, 1'b0));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 7, 1'b0));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 9, 1'b1));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 0, 1'b0));
    settle();

    // directed: channel extremes, label overlay clipping, reads of empty and
    // occupied bins, frame start on a read is ignored, frame start on a pixel clears
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    set_config(1'b0, 25, 1'b1);
    send_item(mk(rmh_pkg::OP_PIXEL, 255, 255, 255, 255, 1'b1));
    send_item(mk(rmh_pkg::OP_PIXEL, 0, 0, 0, 0, 1'b0));
    send_item(mk(rmh_pkg::OP_PIXEL, 255, 0, 0, 1, 1'b0));
    send_item(mk(rmh_pkg::OP_PIXEL, 0, 255, 0, 1, 1'b0));
    send_item(mk(rmh_pkg::OP_PIXEL, 0, 0, 255, 2, 1'b0));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 255, 1'b0));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 0, 1'b0));
    send_item(mk(rmh_pkg::OP_READ, 255, 255, 255, 1, 1'b1));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 2, 1'b0));
    send_item(mk(rmh_pkg::OP_PIXEL, 30, 30, 30, 1, 1'b1));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 1, 1'b0));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 255, 1'b0));
    settle();
    // frozen background, threshold at its top so nothing counts as changed
    set_config(1'b1, 255, 1'b0);
    send_item(mk(rmh_pkg::OP_PIXEL, 255, 255, 255, 3, 1'b1));
    send_item(mk(rmh_pkg::OP_PIXEL, 255, 255, 255, 3, 1'b0));
    send_item(mk(rmh_pkg::OP_PIXEL, 0, 0, 0, 3, 1'b0));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 3, 1'b0));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 4, 1'b0));
    settle();
    set_config(1'b0, 0, 1'b1);
    write_reg(REG_UNUSED, 32'h0);
    send_item(mk(rmh_pkg::OP_PIXEL, 200, 200, 200, 200, 1'b1));
    send_item(mk(rmh_pkg::OP_PIXEL, 200, 200, 200, 200, 1'b1));
    send_item(mk(rmh_pkg::OP_READ, 0, 0, 0, 200, 1'b0));

    // random frames, new settings per chunk, idling switched per chunk
    for (int c = 0; c < 11; c++) begin
      settle();
      set_config($urandom_range(0, 1),
                 (c == 1) ? 0 : ((c == 2) ? 255 : $urandom_range(0, 60)),
                 $urandom_range(0, 1));
      tx_idle_on = (c % 3 != 0);
      rx_idle_on = (c % 4 != 1);
      if (c == 3) begin
        // result side stops for a long stretch while items keep coming,
        // so both internal queues fill and full goes high
        tx_idle_on = 1'b0;
        rx_holdoff = 400;
      end
      for (int k = 0; k < 45; k++) send_item(rand_item(k == 0));
    end
    settle();

    $display("run: %0d input transfers (%0d bin reads), %0d results checked", sb.n_items,
             sb.n_reads, sb.n_checked);
    $display("run: full-rate frames, overlay clipping, threshold extremes, held background");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
